// ===== hw/rtl/gtps_pkg.sv =====
// ----------------------------------------------------------------------------
// Globe terminator pixel shade package
// Shared constants, register indexes and the terminator gradient table.
// ----------------------------------------------------------------------------
package gtps_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_SUN_X = 2'd0;
  localparam logic [1:0] REG_SUN_Y = 2'd1;
  localparam logic [1:0] REG_SUN_Z = 2'd2;

  // Reset value of the sun z component (unit length in Q1.14).
  localparam logic signed [15:0] SUN_Z_RESET = 16'sd16384;

  // Gradient table geometry and shade limits.
  localparam int ROM_DEPTH = 240;
  localparam int ROM_BIAS = 120;
  localparam int LEVEL_LOW = -110;
  localparam int LEVEL_HIGH = 120;
  localparam logic signed [6:0] CLAMP_LOW = -7'sd31;
  localparam logic signed [6:0] CLAMP_HIGH = 7'sd50;
  localparam logic [4:0] VAL_MAX = 5'd31;

  // Palette groups that shade toward a fixed base.
  localparam logic [3:0] GROUP_LAND_A = 4'd1;
  localparam logic [3:0] GROUP_LAND_B = 4'd2;
  localparam logic [7:0] LAND_BASE = 8'd16;

  // Terminator gradient entry for table address idx (level idx - 120),
  // already offset by 16. Flat ends are cut at fixed break points.
  function automatic logic [5:0] gradient_entry(input logic [7:0] idx);
    logic [5:0] res;
    res = 6'(idx - 8'd104);
    if (idx < 8'd54) res = 6'd0;
    else if (idx < 8'd72) res = 6'd1;
    else if (idx < 8'd87) res = 6'd2;
    else if (idx < 8'd98) res = 6'd3;
    else if (idx < 8'd105) res = 6'd4;
    else if (idx < 8'd109) res = 6'd5;
    else if (idx < 8'd111) res = 6'd6;
    else if (idx > 8'd218) res = 6'd34;
    else if (idx > 8'd206) res = 6'd33;
    else if (idx > 8'd194) res = 6'd32;
    else if (idx > 8'd174) res = 6'd31;
    else if (idx > 8'd158) res = 6'd30;
    else if (idx > 8'd146) res = 6'd29;
    else if (idx > 8'd138) res = 6'd28;
    else if (idx > 8'd133) res = 6'd27;
    else if (idx > 8'd130) res = 6'd26;
    else if (idx > 8'd128) res = 6'd25;
    return res;
  endfunction

endpackage

// ===== hw/rtl/gtps_px_if.sv =====
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying one pixel with its normal and noise value.
// ----------------------------------------------------------------------------
interface gtps_px_if;
  logic               valid;
  logic               ready;
  logic [7:0]         pixel_color;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic [14:0]        normal_z;
  logic [1:0]         noise_level;

  modport source (
    output valid, pixel_color, normal_x, normal_y, normal_z, noise_level,
    input  ready
  );
  modport sink (
    input  valid, pixel_color, normal_x, normal_y, normal_z, noise_level,
    output ready
  );
endinterface

// ===== hw/rtl/gtps_shade_if.sv =====
// ----------------------------------------------------------------------------
// Shaded pixel output channel
// Valid/ready channel carrying one shaded palette index.
// ----------------------------------------------------------------------------
interface gtps_shade_if;
  logic       valid;
  logic       ready;
  logic [7:0] shaded_color;

  modport source (output valid, shaded_color, input ready);
  modport sink (input valid, shaded_color, output ready);
endinterface

// ===== hw/rtl/gtps_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and 16-bit write data.
// ----------------------------------------------------------------------------
interface gtps_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/globe_terminator_pixel_shade_unit.sv =====
// ----------------------------------------------------------------------------
// Globe terminator pixel shade unit
// Six-stage pipeline shading palettized globe pixels by sun angle.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    : register writes (0 = sun x, 1 = sun y, 2 = sun z, Q1.14 signed).
//            Always ready; write only while no pixel is in flight.
//   px_in  : one pixel per transaction (color, normal x/y/z, noise).
//   px_out : one shaded palette index per input transaction, in order.
// Each pixel passes through the stage one to stage six registers in order and
// shows on px_out from the stage six register. Throughput is one pixel per
// clock while px_out is ready; the six pipeline registers with their valid
// bits set that figure, with the 18x18 square multipliers in stage two as the
// widest unit.
// Each stage holds its item while the stage after it is full and stalled, so
// a stall on px_out backs up only the stages that are occupied: empty stages
// still take new pixels. Nothing is dropped or repeated under a stall.
// Reset (rst, synchronous) empties the pipeline and returns the sun
// direction to (0, 0, 1.0). The gradient table is constant logic.
// ----------------------------------------------------------------------------
module globe_terminator_pixel_shade_unit
  import gtps_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst,
  gtps_cfg_if.sink    cfg,
  gtps_px_if.sink     px_in,
  gtps_shade_if.source px_out
);

  // Widths of the distance and level terms.
  localparam int TWO_F = 2 * FRAC_BITS;
  localparam int TW = (TWO_F + 3 > 35) ? TWO_F + 3 : 35;
  localparam int NW = TW + 8;
  localparam logic signed [TW-1:0] TWO_ONE = TW'(2) <<< TWO_F;
  localparam logic signed [NW-1:0] NUM_LOW = NW'(LEVEL_LOW) <<< TWO_F;
  localparam logic signed [NW-1:0] NUM_HIGH = NW'(LEVEL_HIGH) <<< TWO_F;
  localparam logic [8:0] IDX_BIAS = 9'(ROM_BIAS);
  localparam logic [8:0] IDX_MAX = 9'(ROM_DEPTH - 1);

  // Sun direction registers.
  logic signed [15:0] sun_x;
  logic signed [15:0] sun_y;
  logic signed [15:0] sun_z;

  // Stage valid bits and per-stage ready.
  logic [6:1] v;
  logic [6:1] rdy;

  // Stage 1: differences.
  logic signed [17:0] dx1, dy1, dz1;
  logic [7:0]         color1;
  logic [1:0]         noise1;
  logic               zero1;
  // Stage 2: squares.
  logic [31:0]        sqx2, sqy2, sqz2;
  logic [7:0]         color2;
  logic [1:0]         noise2;
  logic               zero2;
  // Stage 3: offset distance.
  logic signed [TW-1:0] t3;
  logic [7:0]           color3;
  logic [1:0]           noise3;
  logic                 zero3;
  // Stage 4: level numerator.
  logic signed [NW-1:0] num4;
  logic [7:0]           color4;
  logic [1:0]           noise4;
  logic                 zero4;
  // Stage 5: shade level after noise.
  logic signed [6:0]    r5;
  logic [7:0]           color5;
  logic                 zero5;
  // Stage 6: output register.
  logic [7:0]           shade6;

  // Configuration writes; unknown indexes are ignored.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sun_x <= '0;
      sun_y <= '0;
      sun_z <= SUN_Z_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SUN_X: sun_x <= cfg.data;
        REG_SUN_Y: sun_y <= cfg.data;
        REG_SUN_Z: sun_z <= cfg.data;
        default: ;
      endcase
    end
  end

  // A stage takes a new item when it is empty or its item moves on.
  always_comb begin
    rdy[6] = !v[6] || px_out.ready;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign px_in.ready = rdy[1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= px_in.valid;
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // Stage 1: vector differences and the empty-pixel flag.
  always_ff @(posedge clk) begin
    if (rdy[1] && px_in.valid) begin
      dx1    <= 18'(px_in.normal_x) - 18'(sun_x);
      dy1    <= 18'(px_in.normal_y) - 18'(sun_y);
      dz1    <= $signed({3'b000, px_in.normal_z}) - 18'(sun_z);
      color1 <= px_in.pixel_color;
      noise1 <= px_in.noise_level;
      zero1  <= (px_in.pixel_color == 8'd0) || (px_in.normal_z == 15'd0);
    end
  end

  // Stage 2: squared components, each below 2^32.
  logic signed [35:0] mx, my, mz;
  always_comb begin
    mx = dx1 * dx1;
    my = dy1 * dy1;
    mz = dz1 * dz1;
  end

  always_ff @(posedge clk) begin
    if (rdy[2] && v[1]) begin
      sqx2   <= mx[31:0];
      sqy2   <= my[31:0];
      sqz2   <= mz[31:0];
      color2 <= color1;
      noise2 <= noise1;
      zero2  <= zero1;
    end
  end

  // Stage 3: squared distance minus two.
  always_ff @(posedge clk) begin
    if (rdy[3] && v[2]) begin
      t3 <= $signed(TW'({2'b00, sqx2}) + TW'({2'b00, sqy2}) + TW'({2'b00, sqz2}))
            - TWO_ONE;
      color3 <= color2;
      noise3 <= noise2;
      zero3  <= zero2;
    end
  end

  // Stage 4: times 125 as 128 - 4 + 1.
  logic signed [NW-1:0] t_ext;
  assign t_ext = NW'(t3);

  always_ff @(posedge clk) begin
    if (rdy[4] && v[3]) begin
      num4   <= (t_ext <<< 7) - (t_ext <<< 2) + t_ext;
      color4 <= color3;
      noise4 <= noise3;
      zero4  <= zero3;
    end
  end

  // Stage 5: clamp or gradient lookup, then subtract the noise.
  logic signed [NW-1:0] quo;
  logic [8:0]           quo_t;
  logic [8:0]           idx;
  logic signed [6:0]    level;
  always_comb begin
    quo = num4 >>> TWO_F;
    // Floor shift plus one gives truncation toward zero for negative values.
    quo_t = quo[8:0] + 9'(num4[NW-1] && (|num4[TWO_F-1:0]));
    idx = quo_t + IDX_BIAS;
    if (idx > IDX_MAX) idx = IDX_MAX;
    if (num4 < NUM_LOW) level = CLAMP_LOW;
    else if (num4 > NUM_HIGH) level = CLAMP_HIGH;
    else level = $signed({1'b0, gradient_entry(idx[7:0])});
  end

  always_ff @(posedge clk) begin
    if (rdy[5] && v[4]) begin
      r5     <= level - $signed({5'b00000, noise4});
      color5 <= color4;
      zero5  <= zero4;
    end
  end

  // Stage 6: palette adjustment into the output register.
  logic       land;
  logic [4:0] val;
  logic [8:0] scaled;
  logic [3:0] third;
  logic [8:0] brighter;
  logic [7:0] cap;
  logic [7:0] shade_next;
  always_comb begin
    land = (color5[7:4] == GROUP_LAND_A) || (color5[7:4] == GROUP_LAND_B);
    val = (r5 > $signed({2'b00, VAL_MAX})) ? VAL_MAX : r5[4:0];
    // val / 3 for val up to 31 as (val * 11) >> 5.
    scaled = {4'b0000, val} * 9'd11;
    third = scaled[8:5];
    brighter = {1'b0, color5} + {5'b00000, third};
    cap = {color5[7:4], 4'hF};
    if (zero5) begin
      shade_next = 8'd0;
    end else if (r5 > 7'sd0) begin
      if (land) shade_next = LAND_BASE + {3'b000, val};
      else if (brighter > {1'b0, cap}) shade_next = cap;
      else shade_next = brighter[7:0];
    end else begin
      shade_next = land ? LAND_BASE : color5;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6] && v[5]) begin
      shade6 <= shade_next;
    end
  end

  assign px_out.valid = v[6];
  assign px_out.shaded_color = shade6;

`ifndef SYNTHESIS
  // An empty pixel leaving stage five appears as color zero.
  a_empty_pixel: assert property (@(posedge clk) disable iff (rst)
    v[5] && rdy[6] && zero5 |=> px_out.valid && px_out.shaded_color == 8'd0)
    else $error("empty pixel did not shade to zero");

  // A stalled middle stage keeps its item.
  a_stage3_hold: assert property (@(posedge clk) disable iff (rst)
    v[3] && !rdy[3] |=> v[3] && $stable(t3) && $stable(color3))
    else $error("stage three lost its item under a stall");

  // The noisy shade level stays within the clamp range less the noise.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    v[5] |-> r5 >= -7'sd34 && r5 <= 7'sd50)
    else $error("shade level out of range");
`endif

endmodule
